// ----- sv/assert_macros.svh -----
// Assertion helpers; bodies vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, held off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/uer_pkg.sv -----
package uer_pkg;

   localparam int PRE_LOW_TICKS   = 2;
   localparam int TRIG_HIGH_TICKS = 15;
   localparam int COUNT_W         = 20;

   localparam int TIMEOUT_W = 20;
   localparam int PULSE_W   = 20;
   localparam int DIST_W    = 15;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30000);
   localparam logic [31:0]          PULSE_MAX     = 32'h000F_FFFF;

   // (w + 29) / 58 == ((w + 29) >> 1) / 29, the latter by reciprocal:
   // q = (y * ceil(2^25 / 29)) >> 25, exact for y < 2^20.
   localparam int              DIV_SHIFT = 25;
   localparam logic [20:0]     DIV_MAGIC = 21'd1157050;
   localparam logic [21:0]     DIST_ROUND = 22'd29;

   // CSR decode: register index is paddr[2]
   localparam logic REG_TIMEOUT_IDX = 1'b0;

   // request command (req_tuser)
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // measurement phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LOW  = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;
   localparam logic [1:0] PH_WAIT = 2'd3;

   typedef struct packed {
      logic [DIST_W-1:0]  distance_cm;
      logic [PULSE_W-1:0] echo_width;
      logic               no_object;
      logic               done_res;
      logic               busy_res;
      logic               trig;
   } rsp_type;

   localparam int RSP_W      = $bits(rsp_type);
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

endpackage

// ----- sv/uer_div58.sv -----
module uer_div58
   import uer_pkg::*;
(
   input  logic [PULSE_W-1:0] pulse,
   output logic [DIST_W-1:0]  distance
);

   logic [21:0] rounded;
   logic [20:0] half;
   logic [41:0] product;

   assign rounded  = 22'(pulse) + DIST_ROUND;
   assign half     = rounded[21:1];
   assign product  = 42'(half) * 42'(DIV_MAGIC);
   assign distance = product[DIV_SHIFT +: DIST_W];

endmodule

// ----- sv/uer_ctrl.sv -----
module uer_ctrl
   import uer_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 command,
   input  logic                 echo,
   input  logic [TIMEOUT_W-1:0] wait_limit,
   output rsp_type              result
);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic [1:0]           phase_ff,       phase_in;
   logic [4:0]           phase_ticks_ff, phase_ticks_in;
   logic [TIMEOUT_W-1:0] time_left_ff,   time_left_in;
   logic [COUNT_W-1:0]   width_ff,       width_in;
   logic                 in_pulse_ff,    in_pulse_in;
   logic                 echo_before_ff;

   logic [COUNT_W-1:0]   width_inc;
   logic [PULSE_W-1:0]   pulse_sat;
   logic [DIST_W-1:0]    range_cm;
   logic [31:0]          width_wide;

   // width after this tick's increment (saturating), clamped to the pulse field
   assign width_inc  = (width_ff < COUNT_MAX) ? width_ff + COUNT_W'(1) : width_ff;
   assign width_wide = 32'(width_inc);
   assign pulse_sat  = (width_wide > PULSE_MAX) ? PULSE_W'(PULSE_MAX)
                                                : PULSE_W'(width_wide);

   uer_div58 u_div (
      .pulse    (pulse_sat),
      .distance (range_cm)
   );

   always_comb begin
      logic finished;
      logic rise;
      logic fall;
      logic [4:0] ticks_inc;

      rise      = echo && !echo_before_ff;
      fall      = !echo && echo_before_ff;
      ticks_inc = phase_ticks_ff + 5'd1;
      finished  = 1'b0;

      phase_in       = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      time_left_in   = time_left_ff;
      width_in       = width_ff;
      in_pulse_in    = in_pulse_ff;

      result = '0;

      if (command == CMD_START) begin
         phase_in       = PH_LOW;
         phase_ticks_in = '0;
         time_left_in   = wait_limit;
         width_in       = '0;
         in_pulse_in    = 1'b0;
      end else if (phase_ff != PH_IDLE) begin
         if (in_pulse_ff) begin
            width_in = width_inc;
            if (fall) begin
               finished        = 1'b1;
               result.done_res = 1'b1;
               if (pulse_sat == '0) begin
                  result.no_object = 1'b1;
               end else begin
                  result.echo_width  = pulse_sat;
                  result.distance_cm = range_cm;
               end
            end
         end else if (rise) begin
            width_in    = '0;
            in_pulse_in = 1'b1;
         end

         if (!finished) begin
            case (phase_ff)
               PH_LOW: begin
                  phase_ticks_in = ticks_inc;
                  if (ticks_inc >= 5'(PRE_LOW_TICKS)) begin
                     phase_in       = PH_HIGH;
                     phase_ticks_in = '0;
                  end
               end
               PH_HIGH: begin
                  result.trig    = 1'b1;
                  phase_ticks_in = ticks_inc;
                  if (ticks_inc >= 5'(TRIG_HIGH_TICKS)) begin
                     phase_in       = PH_WAIT;
                     phase_ticks_in = '0;
                  end
               end
               default: begin
                  if (time_left_ff == '0) begin
                     finished         = 1'b1;
                     result.done_res  = 1'b1;
                     result.no_object = 1'b1;
                  end else begin
                     time_left_in = time_left_ff - TIMEOUT_W'(1);
                  end
               end
            endcase
         end

         if (finished) begin
            phase_in       = PH_IDLE;
            phase_ticks_in = '0;
            in_pulse_in    = 1'b0;
         end
      end

      result.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         phase_ticks_ff <= '0;
         time_left_ff   <= '0;
         width_ff       <= '0;
         in_pulse_ff    <= 1'b0;
         echo_before_ff <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         time_left_ff   <= time_left_in;
         width_ff       <= width_in;
         in_pulse_ff    <= in_pulse_in;
         echo_before_ff <= echo;
      end
   end

endmodule

// ----- sv/uer_outbuf.sv -----
module uer_outbuf
   import uer_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    drain;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign drain     = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         out_ff <= skid_valid_ff ? skid_ff : in_data;
      end
      if (!drain && in_valid) begin
         skid_ff <= in_data;
      end
   end

endmodule

// ----- sv/ultrasonic_echo_ranger.sv -----
// Channel | Direction | Payload
// req_    | in        | tuser: command; tdata: echo
// rsp_    | out       | tdata: trig, busy_res, done_res, no_object, echo_width, distance_cm
// csr_    | in (APB)  | wait limit at byte address 0
//
// One item per clock while req_tready is high: state update and result are one
// pass of logic from the state registers into the output register; the /58 is a
// single reciprocal multiply in that pass.
// Synchronous active-high reset; the wait limit comes back as 30000.
// A two-entry output stage (register plus skid) keeps req_tready high while
// one result waits; req_tready drops only when both entries are full.
`include "assert_macros.svh"

module ultrasonic_echo_ranger
   import uer_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] echo, [7:1] zero
   input  logic                  req_tuser,   // [0] command (0 tick, 1 start)

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] trig, [1] busy_res, [2] done_res,
                                              // [3] no_object, [23:4] echo_width,
                                              // [38:24] distance_cm, rest zero

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic                 req_xfer;
   logic                 csr_wr;
   logic                 csr_hit;
   logic [TIMEOUT_W-1:0] timeout_ff;
   rsp_type              step_result;
   rsp_type              rsp_data;

   // input transfer
   assign req_xfer = req_tvalid && req_tready;

   // config port: zero-wait APB, one register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_TIMEOUT_IDX);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? 32'(timeout_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr) begin
         timeout_ff <= csr_pwdata[TIMEOUT_W-1:0];
      end
   end

   // trigger sequencer and echo timer
   uer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (req_xfer),
      .command    (req_tuser),
      .echo       (req_tdata[0]),
      .wait_limit (timeout_ff),
      .result     (step_result)
   );

   // result register with skid entry
   uer_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_xfer),
      .in_ready  (req_tready),
      .in_data   (step_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_data);

   // input stalls only while a result is held at the output
   `ASSERT_IMPLIES(a_stall_needs_held_rsp, clock, reset, !req_tready, rsp_tvalid)
   // no-object results carry no width or distance
   `ASSERT_IMPLIES(a_noobj_zero, clock, reset, rsp_tvalid && rsp_data.no_object,
                   rsp_data.done_res && rsp_data.echo_width == '0 && rsp_data.distance_cm == '0)
   // a finished measurement leaves the block idle
   `ASSERT_IMPLIES(a_done_not_busy, clock, reset, rsp_tvalid && rsp_data.done_res,
                   !rsp_data.busy_res)
   // trigger high only while measuring
   `ASSERT_IMPLIES(a_trig_busy, clock, reset, rsp_tvalid && rsp_data.trig, rsp_data.busy_res)
   // a held result is not replaced
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

endmodule
